/* hdl/u2c_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// u2c_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ---------------------------------------------------------------------------
package u2c_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 16;
    localparam int unsigned PENDING_W = 3;

    localparam logic [CP_W-1:0]      SPACE_CP = 16'h0020;
    localparam logic [5:0]           CONT_MASK = 6'h3f;
    localparam logic [4:0]           LEAD2_MASK = 5'h1f;
    localparam logic [3:0]           LEAD3_MASK = 4'hf;

    // byte counts still to gather or to drop after a lead
    localparam logic [PENDING_W-1:0] PEND_TWO   = 3'd1;
    localparam logic [PENDING_W-1:0] PEND_THREE = 3'd2;
    localparam logic [PENDING_W-1:0] SKIP_FOUR  = 3'd3;
    localparam logic [PENDING_W-1:0] SKIP_FIVE  = 3'd4;
    localparam logic [PENDING_W-1:0] SKIP_SIX   = 3'd5;
    localparam logic [PENDING_W-1:0] PEND_MAX   = SKIP_SIX;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              last_byte;
    } u2c_in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_char;
        logic            end_of_string;
    } u2c_out_t;

    typedef struct packed {
        logic [PENDING_W-1:0] bytes_pending;
        logic                 skipping;
    } u2c_status_t;

endpackage : u2c_pkg
`default_nettype wire

/* hdl/u2c_decode.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// u2c_decode
// Per-byte decode step: sequence state registers plus the combinational
// update that turns one byte into zero or one code point.
// ---------------------------------------------------------------------------
module u2c_decode (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   step,
    input  u2c_pkg::u2c_in_t      item,
    output logic                  res_valid,
    output u2c_pkg::u2c_out_t     res,
    output u2c_pkg::u2c_status_t  status
);
    import u2c_pkg::*;

    logic [PENDING_W-1:0] pending_reg, pending_next;
    logic                 skipping_reg, skipping_next;
    logic [CP_W-1:0]      partial_reg, partial_next;

    logic [PENDING_W-1:0] pend_dec;
    logic [CP_W-1:0]      shifted;
    logic [BYTE_W-1:0]    b;
    logic                 last;

    assign b        = item.in_byte;
    assign last     = item.last_byte;
    assign pend_dec = pending_reg - PENDING_W'(1);
    assign shifted  = {partial_reg[CP_W-7:0], b[5:0] & CONT_MASK};

    always_comb begin
        pending_next  = pending_reg;
        skipping_next = skipping_reg;
        partial_next  = partial_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (pending_reg != '0) begin
            if (skipping_reg) begin
                if (last) begin
                    pending_next  = '0;
                    skipping_next = 1'b0;
                    partial_next  = '0;
                    res_valid     = 1'b1;
                    res           = '{code_point: '0, has_char: 1'b0, end_of_string: 1'b1};
                end else begin
                    pending_next = pend_dec;
                    if (pend_dec == '0) begin
                        skipping_next = 1'b0;
                    end
                end
            end else if (pend_dec == '0) begin
                pending_next = '0;
                partial_next = '0;
                res_valid    = 1'b1;
                res          = '{code_point: shifted, has_char: 1'b1, end_of_string: last};
            end else if (last) begin
                pending_next = '0;
                partial_next = '0;
                res_valid    = 1'b1;
                res          = '{code_point: SPACE_CP, has_char: 1'b1, end_of_string: 1'b1};
            end else begin
                pending_next = pend_dec;
                partial_next = shifted;
            end
        end else if (!b[7]) begin
            partial_next = '0;
            res_valid    = 1'b1;
            res          = '{code_point: CP_W'(b), has_char: 1'b1, end_of_string: last};
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
            if (last) begin
                partial_next = '0;
                res_valid    = 1'b1;
                res          = '{code_point: SPACE_CP, has_char: 1'b1, end_of_string: 1'b1};
            end else if (b[5] == 1'b0) begin
                partial_next = CP_W'(b[4:0] & LEAD2_MASK);
                pending_next = PEND_TWO;
            end else begin
                partial_next = CP_W'(b[3:0] & LEAD3_MASK);
                pending_next = PEND_THREE;
            end
        end else begin
            // unsupported lead or stray continuation: space now, drop the tail
            partial_next = '0;
            res_valid    = 1'b1;
            res          = '{code_point: SPACE_CP, has_char: 1'b1, end_of_string: last};
            if (!last) begin
                skipping_next = 1'b1;
                if (b[7:3] == 5'b11110) begin
                    pending_next = SKIP_FOUR;
                end else if (b[7:2] == 6'b111110) begin
                    pending_next = SKIP_FIVE;
                end else begin
                    pending_next = SKIP_SIX;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            skipping_reg <= 1'b0;
            partial_reg  <= '0;
        end else if (step) begin
            pending_reg  <= pending_next;
            skipping_reg <= skipping_next;
            partial_reg  <= partial_next;
        end
    end

    assign status = '{bytes_pending: pending_reg, skipping: skipping_reg};

endmodule : u2c_decode
`default_nettype wire

/* hdl/utf8_to_codepoint_decoder.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// UTF-8 byte stream in, 16-bit code points out.
//
// Input channel s_*: one byte per transfer with a flag on the final byte of
// the string. Result channel m_*: code point, has_char and end_of_string.
// Two-byte and three-byte sequences give a result on their final byte; lead
// and middle bytes give none. Unsupported leads and stray continuation bytes
// give a space and the following bytes of that sequence are dropped. The
// final byte of a string always gives a result with end_of_string set.
// A byte lands in the input register at the transfer edge; its result, if any,
// is written to the output register once that register is free or draining,
// and m_valid rises. Throughput: one byte per cycle while the receiver does
// not stall, set by the single decode step between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register holds at most one byte, with s_ready low while it is full.
// Reset (aresetn low, synchronous) empties both registers and clears the
// sequence state.
// ---------------------------------------------------------------------------
module utf8_to_codepoint_decoder (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  u2c_pkg::u2c_in_t   s_item,
    output logic               m_valid,
    input  wire                m_ready,
    output u2c_pkg::u2c_out_t  m_item
);
    import u2c_pkg::*;

    logic        in_valid_reg;
    u2c_in_t     in_data_reg;
    logic        out_valid_reg;
    u2c_out_t    out_data_reg;

    logic        advance;
    logic        res_valid;
    u2c_out_t    res;
    u2c_status_t status;

    // advance the held byte once the output register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    u2c_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_data_reg;

    a_skip_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        status.skipping |-> status.bytes_pending != '0)
        else $error("skipping set with no bytes left to drop");

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.bytes_pending <= PEND_MAX)
        else $error("pending byte count out of range");

    a_last_gives_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.last_byte |=>
            m_valid && m_item.end_of_string && status.bytes_pending == '0 && !status.skipping)
        else $error("final byte did not close the string");

    a_bare_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.has_char |-> m_item.end_of_string)
        else $error("result without character is not an end marker");

endmodule : utf8_to_codepoint_decoder
`default_nettype wire
